/* rtl/skt_pkg.sv */
// ----------------------------------------------------------------------------
// skt_pkg
// Shared types and codes of the sorted key table: request and result items,
// operation and status codes, controller states.
// ----------------------------------------------------------------------------
`default_nettype none

package skt_pkg;

   localparam int unsigned KEY_W = 32;

   // operation codes
   localparam logic [1:0] FUNC_INSERT = 2'd0;
   localparam logic [1:0] FUNC_REMOVE = 2'd1;
   localparam logic [1:0] FUNC_LOOKUP = 2'd2;
   localparam logic [1:0] FUNC_CLEAR  = 2'd3;

   // status codes
   localparam logic [1:0] ST_OK     = 2'd0;
   localparam logic [1:0] ST_FULL   = 2'd1;
   localparam logic [1:0] ST_ABSENT = 2'd2;

   typedef struct packed {
      logic [1:0]       func;
      logic [KEY_W-1:0] key_value;
   } req_item_type;

   typedef struct packed {
      logic [1:0] status;
      logic       found;
      logic [5:0] position;
      logic [6:0] entry_count;
   } rsp_item_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_READ,
      S_COMPARE,
      S_SHIFT,
      S_PLACE,
      S_RESULT
   } ctrl_state_type;

endpackage

`default_nettype wire

/* rtl/skt_ram.sv */
// ----------------------------------------------------------------------------
// skt_ram
// Generic simple dual-port RAM: one write port, one read port with the read
// data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module skt_ram #(
   parameter int unsigned WIDTH = 32,
   parameter int unsigned DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

/* rtl/skt_ctrl.sv */
// ----------------------------------------------------------------------------
// skt_ctrl
// Sequencer of the sorted key table: binary search over the key memory,
// then a one-entry-per-cycle shift up (insert) or down (remove).
// ----------------------------------------------------------------------------
`default_nettype none

module skt_ctrl
   import skt_pkg::*;
#(
   parameter int unsigned CAPACITY = 64
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_valid,
   input  wire req_item_type                req_item,
   output logic                             req_stall,
   output logic                             mem_rd_en,
   output logic [$clog2(CAPACITY)-1:0]      mem_rd_addr,
   input  wire logic [KEY_W-1:0]            mem_rd_data,
   output logic                             mem_wr_en,
   output logic [$clog2(CAPACITY)-1:0]      mem_wr_addr,
   output logic [KEY_W-1:0]                 mem_wr_data,
   input  wire logic                        out_free,
   output logic                             rsp_load,
   output rsp_item_type                     rsp_res
);

   localparam int unsigned AW = $clog2(CAPACITY);
   localparam int unsigned CW = $clog2(CAPACITY + 1);
   localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);
   localparam logic [CW-1:0] ONE_C = CW'(1);

   ctrl_state_type   state_ff, state_in;
   logic [1:0]       op_ff, op_in;
   logic [KEY_W-1:0] key_ff, key_in;
   logic [CW-1:0]    lo_ff, lo_in;
   logic [CW-1:0]    hi_ff, hi_in;
   logic             eq_ff, eq_in;
   logic [CW-1:0]    cur_ff, cur_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             pend_ff, pend_in;
   logic [AW-1:0]    pend_addr_ff, pend_addr_in;
   rsp_item_type     res_ff, res_in;

   logic [CW-1:0]    mid;
   logic             go_right;
   logic             req_accept;

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
         pend_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         pend_ff  <= pend_in;
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      op_ff        <= op_in;
      key_ff       <= key_in;
      lo_ff        <= lo_in;
      hi_ff        <= hi_in;
      eq_ff        <= eq_in;
      cur_ff       <= cur_in;
      pend_addr_ff <= pend_addr_in;
      res_ff       <= res_in;
   end

   assign req_stall  = (state_ff != S_IDLE);
   assign req_accept = req_valid && !req_stall;

   // search midpoint and direction
   assign mid = lo_ff + ((hi_ff - lo_ff) >> 1);
   always_comb begin
      if (op_ff == FUNC_INSERT) begin
         go_right = (mem_rd_data <= key_ff);
      end else begin
         go_right = (mem_rd_data < key_ff);
      end
   end

   // memory write port: shifted entry in the cycle after its read, or the new key
   always_comb begin
      if (state_ff == S_PLACE) begin
         mem_wr_en   = 1'b1;
         mem_wr_addr = AW'(lo_ff);
         mem_wr_data = key_ff;
      end else begin
         mem_wr_en   = pend_ff;
         mem_wr_addr = pend_addr_ff;
         mem_wr_data = mem_rd_data;
      end
   end

   assign rsp_res = res_ff;

   // next state and outputs
   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      key_in       = key_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      eq_in        = eq_ff;
      cur_in       = cur_ff;
      count_in     = count_ff;
      pend_in      = 1'b0;
      pend_addr_in = pend_addr_ff;
      res_in       = res_ff;
      mem_rd_en    = 1'b0;
      mem_rd_addr  = AW'(mid);
      rsp_load     = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               op_in  = req_item.func;
               key_in = req_item.key_value;
               lo_in  = '0;
               hi_in  = count_ff;
               eq_in  = 1'b0;
               res_in = '0;
               if (req_item.func == FUNC_CLEAR) begin
                  count_in = '0;
                  state_in = S_RESULT;
               end else if (req_item.func == FUNC_INSERT && count_ff >= CAP_C) begin
                  res_in.status      = ST_FULL;
                  res_in.entry_count = 7'(count_ff);
                  state_in           = S_RESULT;
               end else begin
                  state_in = S_READ;
               end
            end
         end

         // issue one probe, or finish the search with lo as the bound
         S_READ: begin
            if (lo_ff < hi_ff) begin
               mem_rd_en = 1'b1;
               state_in  = S_COMPARE;
            end else if (op_ff == FUNC_INSERT) begin
               cur_in   = count_ff;
               state_in = S_SHIFT;
            end else if (!eq_ff) begin
               res_in.status      = ST_ABSENT;
               res_in.entry_count = 7'(count_ff);
               state_in           = S_RESULT;
            end else if (op_ff == FUNC_LOOKUP) begin
               res_in.found       = 1'b1;
               res_in.position    = 6'(lo_ff);
               res_in.entry_count = 7'(count_ff);
               state_in           = S_RESULT;
            end else begin
               cur_in   = lo_ff;
               state_in = S_SHIFT;
            end
         end

         // narrow the interval; remember whether the upper bound probe matched
         S_COMPARE: begin
            if (go_right) begin
               lo_in = mid + ONE_C;
            end else begin
               hi_in = mid;
               eq_in = (mem_rd_data == key_ff);
            end
            state_in = S_READ;
         end

         S_SHIFT: begin
            if (op_ff == FUNC_INSERT) begin
               // move entries up, highest first
               if (cur_ff > lo_ff) begin
                  mem_rd_en    = 1'b1;
                  mem_rd_addr  = AW'(cur_ff - ONE_C);
                  pend_in      = 1'b1;
                  pend_addr_in = AW'(cur_ff);
                  cur_in       = cur_ff - ONE_C;
               end else begin
                  state_in = S_PLACE;
               end
            end else begin
               // move entries down, lowest first
               if ((cur_ff + ONE_C) < count_ff) begin
                  mem_rd_en    = 1'b1;
                  mem_rd_addr  = AW'(cur_ff + ONE_C);
                  pend_in      = 1'b1;
                  pend_addr_in = AW'(cur_ff);
                  cur_in       = cur_ff + ONE_C;
               end else begin
                  count_in           = count_ff - ONE_C;
                  res_in.found       = 1'b1;
                  res_in.position    = 6'(lo_ff);
                  res_in.entry_count = 7'(count_ff - ONE_C);
                  state_in           = S_RESULT;
               end
            end
         end

         S_PLACE: begin
            count_in           = count_ff + ONE_C;
            res_in.position    = 6'(lo_ff);
            res_in.entry_count = 7'(count_ff + ONE_C);
            state_in           = S_RESULT;
         end

         // hand the result to the output register once it is free
         S_RESULT: begin
            if (out_free) begin
               rsp_load = 1'b1;
               state_in = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

/* rtl/sorted_key_table.sv */
// ----------------------------------------------------------------------------
// sorted_key_table
// Bounded store of unsigned keys kept in ascending order, with insert,
// remove, lookup and clear requests and one result item per request.
// ----------------------------------------------------------------------------
// The block holds up to CAPACITY keys in a single key memory and serves one
// request at a time. A lookup binary-searches the memory, one probe at a
// time. An insert then moves up each key behind the new key, a remove moves
// down each key after the removed one, both through the one write port of
// the key memory. Clear and an insert into a full store skip the search. A
// new request is taken while the previous result still waits in the output
// register. Position and entry_count are the low bits of the index and of
// the count. No memory clearing pass is needed after reset.
`default_nettype none

module sorted_key_table
   import skt_pkg::*;
#(
   parameter int unsigned CAPACITY = 64
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   input  wire req_item_type req_item,
   output logic              req_stall,
   output logic              rsp_valid,
   output rsp_item_type      rsp_item,
   input  wire logic         rsp_stall
);

   localparam int unsigned AW = $clog2(CAPACITY);

   logic             mem_rd_en;
   logic [AW-1:0]    mem_rd_addr;
   logic [KEY_W-1:0] mem_rd_data;
   logic             mem_wr_en;
   logic [AW-1:0]    mem_wr_addr;
   logic [KEY_W-1:0] mem_wr_data;
   logic             out_free;
   logic             rsp_load;
   rsp_item_type     rsp_res;

   logic             rsp_valid_ff, rsp_valid_in;
   rsp_item_type     rsp_item_ff, rsp_item_in;

   // key memory
   skt_ram #(
      .WIDTH (KEY_W),
      .DEPTH (CAPACITY)
   ) u_key_ram (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   // search and shift sequencer
   skt_ctrl #(
      .CAPACITY (CAPACITY)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_item    (req_item),
      .req_stall   (req_stall),
      .mem_rd_en   (mem_rd_en),
      .mem_rd_addr (mem_rd_addr),
      .mem_rd_data (mem_rd_data),
      .mem_wr_en   (mem_wr_en),
      .mem_wr_addr (mem_wr_addr),
      .mem_wr_data (mem_wr_data),
      .out_free    (out_free),
      .rsp_load    (rsp_load),
      .rsp_res     (rsp_res)
   );

   // output register
   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      rsp_valid_in = rsp_load || (rsp_valid_ff && rsp_stall);
      rsp_item_in  = rsp_load ? rsp_res : rsp_item_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_item_ff <= rsp_item_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

   // a result is never loaded in the cycle a request is taken
   a_no_early_result: assert property (
      @(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |-> !rsp_load
   ) else $error("result loaded while a request is taken");

   // a matched key always reports ok status
   a_found_ok: assert property (
      @(posedge clock) disable iff (reset)
      (rsp_valid && rsp_item.found) |-> (rsp_item.status == ST_OK)
   ) else $error("found flag with non-ok status");

   // failed requests report index zero
   a_fail_pos_zero: assert property (
      @(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_item.status == ST_FULL || rsp_item.status == ST_ABSENT))
         |-> (rsp_item.position == 6'd0 && !rsp_item.found)
   ) else $error("failed request carries an index");

   // the output register is never overwritten while it holds an unaccepted item
   a_no_overwrite: assert property (
      @(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stall) |-> !rsp_load
   ) else $error("result overwritten while stalled");

endmodule

`default_nettype wire

/* tb/sv/testbench.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the sorted key table. A short table of directed
// requests covers empty and duplicate-key cases and the key extremes, then
// episodes of random requests fill, churn and drain the store. Each result
// is checked field by field against an in-order shadow copy of the store, or
// a typed row's own result, while both channels idle and stall.
// ----------------------------------------------------------------------------

module testbench;
   import skt_pkg::*;

   localparam int unsigned CAPACITY      = 64;
   localparam int unsigned RANDOM_ITEMS  = 800;
   localparam int unsigned HOLD_OFF      = 300;
   localparam int unsigned SETTLE_CYCLES = 100;
   localparam int unsigned IDLE_LIMIT    = 3000;
   localparam int unsigned POOL_DEPTH    = 64;

   // receiver stall patterns
   localparam int STALL_NONE     = 0;
   localparam int STALL_RANDOM   = 1;
   localparam int STALL_PERIODIC = 2;

   typedef struct packed {
      logic [1:0]       func;
      logic [KEY_W-1:0] key_value;
      logic             typed;
      rsp_item_type     rsp;
   } directed_row_type;

   localparam int unsigned DIRECTED_COUNT = 22;

   // directed requests; typed rows carry the result read straight off the spec
   localparam directed_row_type DIRECTED_ROWS [DIRECTED_COUNT] = '{
      '{FUNC_LOOKUP, 32'h0000_0000, 1'b1, '{ST_ABSENT, 1'b0, 6'd0, 7'd0}},
      '{FUNC_REMOVE, 32'hFFFF_FFFF, 1'b1, '{ST_ABSENT, 1'b0, 6'd0, 7'd0}},
      '{FUNC_CLEAR,  32'h1234_5678, 1'b1, '{ST_OK,     1'b0, 6'd0, 7'd0}},
      '{FUNC_INSERT, 32'h8000_0000, 1'b1, '{ST_OK,     1'b0, 6'd0, 7'd1}},
      '{FUNC_INSERT, 32'h0000_0000, 1'b1, '{ST_OK,     1'b0, 6'd0, 7'd2}},
      '{FUNC_INSERT, 32'hFFFF_FFFF, 1'b1, '{ST_OK,     1'b0, 6'd2, 7'd3}},
      '{FUNC_INSERT, 32'h8000_0000, 1'b1, '{ST_OK,     1'b0, 6'd2, 7'd4}},
      '{FUNC_INSERT, 32'h8000_0000, 1'b1, '{ST_OK,     1'b0, 6'd3, 7'd5}},
      '{FUNC_LOOKUP, 32'h8000_0000, 1'b1, '{ST_OK,     1'b1, 6'd1, 7'd5}},
      '{FUNC_LOOKUP, 32'hFFFF_FFFF, 1'b1, '{ST_OK,     1'b1, 6'd4, 7'd5}},
      '{FUNC_LOOKUP, 32'h7FFF_FFFF, 1'b1, '{ST_ABSENT, 1'b0, 6'd0, 7'd5}},
      '{FUNC_REMOVE, 32'h8000_0000, 1'b1, '{ST_OK,     1'b1, 6'd1, 7'd4}},
      '{FUNC_REMOVE, 32'h0000_0000, 1'b1, '{ST_OK,     1'b1, 6'd0, 7'd3}},
      '{FUNC_LOOKUP, 32'h8000_0000, 1'b1, '{ST_OK,     1'b1, 6'd0, 7'd3}},
      '{FUNC_REMOVE, 32'h0000_0001, 1'b1, '{ST_ABSENT, 1'b0, 6'd0, 7'd3}},
      '{FUNC_INSERT, 32'h5555_AAAA, 1'b0, '0},
      '{FUNC_INSERT, 32'hAAAA_5555, 1'b0, '0},
      '{FUNC_LOOKUP, 32'hAAAA_5555, 1'b0, '0},
      '{FUNC_REMOVE, 32'hFFFF_FFFF, 1'b0, '0},
      '{FUNC_CLEAR,  32'hFFFF_FFFF, 1'b1, '{ST_OK,     1'b0, 6'd0, 7'd0}},
      '{FUNC_REMOVE, 32'h0000_0000, 1'b1, '{ST_ABSENT, 1'b0, 6'd0, 7'd0}},
      '{FUNC_INSERT, 32'hFFFF_FFFF, 1'b1, '{ST_OK,     1'b0, 6'd0, 7'd1}}
   };

   logic         clock;
   logic         reset;
   logic         req_valid;
   req_item_type req_item;
   logic         req_stall;
   logic         rsp_valid;
   rsp_item_type rsp_item;
   logic         rsp_stall;

   // bench-side tag that travels with the request item
   logic         req_typed;
   rsp_item_type req_typed_rsp;

   // shadow of the key store
   logic [KEY_W-1:0] shadow_keys [CAPACITY];
   int unsigned      shadow_count = 0;

   rsp_item_type     awaited_results [$];
   logic [KEY_W-1:0] key_pool [$];

   int unsigned error_count     = 0;
   int unsigned requests_sent   = 0;
   int unsigned results_checked = 0;
   int unsigned func_seen [4]   = '{0, 0, 0, 0};
   int unsigned status_seen [4] = '{0, 0, 0, 0};
   int unsigned burst_left      = 0;
   int unsigned idle_cycles     = 0;
   int          stall_mode      = STALL_NONE;
   bit          no_gaps         = 1'b0;
   bit          hold_off_start  = 1'b0;

   sorted_key_table #(
      .CAPACITY(CAPACITY)
   ) uut (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_item (req_item),
      .req_stall(req_stall),
      .rsp_valid(rsp_valid),
      .rsp_item (rsp_item),
      .rsp_stall(rsp_stall)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // sorted-store update; returns the result the request should produce
   function automatic rsp_item_type apply_to_shadow(req_item_type item);
      rsp_item_type res;
      int unsigned  slot;
      int unsigned  idx;
      res = '0;
      res.status = ST_OK;
      slot = 0;
      case (item.func)
         FUNC_INSERT: begin
            if (shadow_count >= CAPACITY) begin
               res.status = ST_FULL;
            end else begin
               // goes after every key equal to it
               while (slot < shadow_count && shadow_keys[slot] <= item.key_value)
                  slot++;
               for (idx = shadow_count; idx > slot; idx--)
                  shadow_keys[idx] = shadow_keys[idx-1];
               shadow_keys[slot] = item.key_value;
               shadow_count++;
               res.position = slot[5:0];
            end
         end
         FUNC_REMOVE, FUNC_LOOKUP: begin
            // lowest index holding a key not below the request
            while (slot < shadow_count && shadow_keys[slot] < item.key_value)
               slot++;
            if (slot < shadow_count && shadow_keys[slot] == item.key_value) begin
               res.found = 1'b1;
               res.position = slot[5:0];
               if (item.func == FUNC_REMOVE) begin
                  shadow_count--;
                  for (idx = slot; idx < shadow_count; idx++)
                     shadow_keys[idx] = shadow_keys[idx+1];
               end
            end else begin
               res.status = ST_ABSENT;
            end
         end
         default: begin
            shadow_count = 0;
         end
      endcase
      res.entry_count = shadow_count[6:0];
      return res;
   endfunction

   task automatic compare_result(input rsp_item_type got, input rsp_item_type want);
      if (got.status !== want.status) begin
         $error("status: expected %0d, got %0d", want.status, got.status);
         error_count++;
      end
      if (got.found !== want.found) begin
         $error("found: expected %0d, got %0d", want.found, got.found);
         error_count++;
      end
      if (got.position !== want.position) begin
         $error("position: expected %0d, got %0d", want.position, got.position);
         error_count++;
      end
      if (got.entry_count !== want.entry_count) begin
         $error("entry_count: expected %0d, got %0d", want.entry_count, got.entry_count);
         error_count++;
      end
   endtask

   // both channels: predict at request acceptance, check at result acceptance
   always @(posedge clock) begin : monitor
      rsp_item_type want;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (awaited_results.size() == 0) begin
               $error("result item with no request outstanding");
               error_count++;
            end else begin
               want = awaited_results.pop_front();
               compare_result(rsp_item, want);
               status_seen[want.status]++;
               results_checked++;
            end
         end
         if (req_valid && !req_stall) begin
            want = apply_to_shadow(req_item);
            if (req_typed)
               want = req_typed_rsp;
            awaited_results.push_back(want);
            func_seen[req_item.func]++;
         end
      end
   end

   // watchdog on cycles with no handshake on either channel
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            idle_cycles = 0;
         else
            idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("testbench: errors");
            $finish;
         end
      end
   end

   // receiver stall patterns and the long hold-off
   initial begin : receiver
      int unsigned phase;
      phase = 0;
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         phase++;
         if (hold_off_start) begin
            hold_off_start = 1'b0;
            rsp_stall <= 1'b1;
            repeat (HOLD_OFF) @(posedge clock);
         end else begin
            case (stall_mode)
               STALL_RANDOM:   rsp_stall <= ($urandom_range(0, 99) < 35);
               STALL_PERIODIC: rsp_stall <= ((phase % 7) < 3);
               default:        rsp_stall <= 1'b0;
            endcase
         end
      end
   end

   // offer one request item and wait until it is taken
   task automatic send_request(input logic [1:0] func, input logic [KEY_W-1:0] key,
                               input logic typed, input rsp_item_type typed_rsp);
      req_item_type item;
      item.func = func;
      item.key_value = key;
      if (burst_left == 0) begin
         if (!no_gaps) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clock);
         end
         burst_left = $urandom_range(1, 12);
      end
      burst_left--;
      req_valid     <= 1'b1;
      req_item      <= item;
      req_typed     <= typed;
      req_typed_rsp <= typed_rsp;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      requests_sent++;
      if (func == FUNC_INSERT) begin
         key_pool.push_back(key);
         if (key_pool.size() > POOL_DEPTH)
            void'(key_pool.pop_front());
      end
   endtask

   task automatic send_random(input logic [1:0] func, input logic [KEY_W-1:0] key);
      send_request(func, key, 1'b0, '0);
   endtask

   // sender pause until every outstanding result has arrived
   task automatic wait_for_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (awaited_results.size() != 0);
   endtask

   // key mix: held keys, their neighbors, extremes, a small range, anything
   function automatic logic [KEY_W-1:0] pick_key();
      int unsigned      sel;
      logic [KEY_W-1:0] held;
      sel = $urandom_range(0, 99);
      held = (key_pool.size() > 0) ? key_pool[$urandom_range(0, key_pool.size()-1)]
                                   : $urandom();
      if (sel < 45)
         return held;
      else if (sel < 55)
         return $urandom_range(0, 1) ? held + 1 : held - 1;
      else if (sel < 62)
         return $urandom_range(0, 1) ? '0 : '1;
      else if (sel < 75)
         return $urandom_range(0, 15);
      return $urandom();
   endfunction

   // stimulus
   initial begin : stimulus
      int unsigned row;
      int unsigned episode;
      int unsigned span;
      int unsigned pick;
      int unsigned first_random;
      int unsigned n;

      reset         <= 1'b1;
      req_valid     <= 1'b0;
      req_item      <= '0;
      req_typed     <= 1'b0;
      req_typed_rsp <= '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed table
      for (row = 0; row < DIRECTED_COUNT; row++)
         send_request(DIRECTED_ROWS[row].func, DIRECTED_ROWS[row].key_value,
                      DIRECTED_ROWS[row].typed, DIRECTED_ROWS[row].rsp);

      // random episodes; the first fills the store past capacity
      first_random = requests_sent;
      episode = 0;
      while (requests_sent - first_random < RANDOM_ITEMS) begin
         stall_mode = $urandom_range(STALL_NONE, STALL_PERIODIC);
         no_gaps = ($urandom_range(0, 3) == 0);
         if (episode == 2)
            hold_off_start = 1'b1;
         pick = (episode == 0) ? 0 : $urandom_range(0, 9);
         if (pick < 2) begin
            // fill toward capacity and beyond, with some lookups
            send_random(FUNC_CLEAR, $urandom());
            span = (episode == 0) ? CAPACITY + 3 : $urandom_range(55, 72);
            for (n = 0; n < span; n++) begin
               if ($urandom_range(0, 4) == 0)
                  send_random(FUNC_LOOKUP, pick_key());
               send_random(FUNC_INSERT, pick_key());
            end
         end else if (pick < 7) begin
            // general churn
            span = $urandom_range(20, 60);
            for (n = 0; n < span; n++) begin
               case ($urandom_range(0, 99)) inside
                  [0:37]:  send_random(FUNC_INSERT, pick_key());
                  [38:66]: send_random(FUNC_REMOVE, pick_key());
                  [67:97]: send_random(FUNC_LOOKUP, pick_key());
                  default: send_random(FUNC_CLEAR, $urandom());
               endcase
            end
         end else begin
            // drain: mostly removes, so the store empties and removes miss
            span = $urandom_range(30, 70);
            for (n = 0; n < span; n++)
               send_random($urandom_range(0, 3) == 0 ? FUNC_LOOKUP : FUNC_REMOVE,
                           pick_key());
         end
         if (episode == 4 || $urandom_range(0, 5) == 0)
            wait_for_results();
         episode++;
      end

      // let the last results come out, then a settling stretch
      stall_mode = STALL_RANDOM;
      wait_for_results();
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("covered %0d requests: %0d insert, %0d remove, %0d lookup, %0d clear",
               requests_sent, func_seen[FUNC_INSERT], func_seen[FUNC_REMOVE],
               func_seen[FUNC_LOOKUP], func_seen[FUNC_CLEAR]);
      $display("checked %0d results: %0d ok, %0d full-store rejects, %0d misses",
               results_checked, status_seen[ST_OK], status_seen[ST_FULL],
               status_seen[ST_ABSENT]);
      if (error_count == 0 && awaited_results.size() == 0)
         $display("testbench: clean");
      else
         $display("testbench: errors");
      $finish;
   end

endmodule
